// ----- rtl/rbcs_pkg.sv -----
// Package for the rank-by-counting block: sizes, item payload types and the
// control bundle between the sequencer and the shared compare unit.
// No dependencies.
`default_nettype none

package rbcs_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VALUE_W   = 32;
   localparam int RANK_W    = 6;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_final;
   } rbcs_req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              end_of_ranks;
      logic              overflow;
   } rbcs_rsp_type;

   typedef struct packed {
      logic key_load;   // capture key from read data and clear the count
      logic enable;     // compare read data against key and count
   } rbcs_rank_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/rank_by_counting_smaller.sv -----
// Rank-by-counting block, top level. Depends on rbcs_pkg, rbcs_store and
// rbcs_rank_unit.
//
// Usage: signed 32-bit values come in on the req_ channel, one per item,
// and are stored in load order. The item flagged is_final ends the sequence;
// the block then sends one rsp_ item per stored value, in load order, whose
// rank is the number of stored values strictly smaller. The last rank carries
// end_of_ranks; overflow is set on every rank of a sequence in which values
// beyond the 64-entry store were dropped.
// Loading accepts one item per cycle. After the final item, each rank goes
// through key read, read latency, one compare per stored value through the
// single read port and shared comparator, and send. req_ready is low while
// ranks are being computed. Results go through an output register: the next
// key walk runs while a rank waits; a stalled receiver holds the sequencer
// only once the next rank is ready. Reset clears the count, the drop flag and
// the output valid; store contents are not cleared, and no unwritten entry is
// ever used.
`default_nettype none

module rank_by_counting_smaller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rbcs_pkg::rbcs_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rbcs_pkg::rbcs_rsp_type      rsp_data
);
   import rbcs_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_KEY,
      S_KEYW,
      S_WALK,
      S_SEND
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rbcs_rsp_type       rsp_ff, rsp_in;

   logic               req_go, wr_en, send_go, last_idx;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [RANK_W-1:0]  rank_count;
   rbcs_rank_ctl_type  rank_ctl;

   assign req_ready = (state_ff == S_LOAD);
   assign req_go    = req_valid && req_ready;
   assign wr_en     = req_go && (count_ff < CNT_W'(MAX_ITEMS));
   assign send_go   = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_ready);
   assign last_idx  = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;

   rbcs_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rbcs_rank_unit u_rank (
      .clock (clock),
      .ctl   (rank_ctl),
      .data  (rd_data),
      .count (rank_count)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff;
      rank_ctl     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_go) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.is_final) begin
                  idx_in   = '0;
                  state_in = S_KEY;
               end
            end
         end
         S_KEY: begin
            rd_addr  = idx_ff;
            state_in = S_KEYW;
         end
         S_KEYW: begin
            // key arrives now; start the walk at entry zero
            rank_ctl.key_load = 1'b1;
            rd_addr           = '0;
            walk_in           = CNT_W'(1);
            state_in          = S_WALK;
         end
         S_WALK: begin
            rank_ctl.enable = 1'b1;
            rd_addr         = walk_ff[IDX_W-1:0];
            if (walk_ff == count_ff) begin
               state_in = S_SEND;
            end else begin
               walk_in = walk_ff + CNT_W'(1);
            end
         end
         S_SEND: begin
            if (send_go) begin
               rsp_valid_in        = 1'b1;
               rsp_in.rank         = rank_count;
               rsp_in.end_of_ranks = last_idx;
               rsp_in.overflow     = dropped_ff;
               if (last_idx) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_KEY;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      walk_ff <= walk_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("stored count above capacity");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (walk_ff <= count_ff && walk_ff != '0))
      else $error("walk index outside stored range");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND) |-> ({1'b0, rank_count} < count_ff))
      else $error("rank not below stored count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (send_go && last_idx) |=> (count_ff == '0 && !dropped_ff && rsp_valid
                                 && rsp_data.end_of_ranks))
      else $error("sequence state not cleared after last rank");

endmodule

`default_nettype wire

// ----- rtl/rbcs_store.sv -----
// Value store of the rank-by-counting block: one write port, one read port
// with registered read data. Depends on rbcs_pkg.
`default_nettype none

module rbcs_store (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [rbcs_pkg::IDX_W-1:0]  wr_addr,
   input  wire logic [rbcs_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [rbcs_pkg::IDX_W-1:0]  rd_addr,
   output logic      [rbcs_pkg::VALUE_W-1:0] rd_data
);
   import rbcs_pkg::*;

   logic [VALUE_W-1:0] mem_ff [MAX_ITEMS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/rbcs_rank_unit.sv -----
// Shared compare-and-count unit: holds the key and counts stored values that
// are strictly smaller, one per cycle while enable is set. Depends on rbcs_pkg.
`default_nettype none

module rbcs_rank_unit (
   input  wire logic                          clock,
   input  wire rbcs_pkg::rbcs_rank_ctl_type   ctl,
   input  wire logic [rbcs_pkg::VALUE_W-1:0]  data,
   output logic      [rbcs_pkg::RANK_W-1:0]   count
);
   import rbcs_pkg::*;

   logic [VALUE_W-1:0] key_ff, key_in;
   logic [RANK_W-1:0]  count_ff, count_in;
   logic               less;

   assign less = $signed(data) < $signed(key_ff);

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.key_load) begin
         key_in   = data;
         count_in = '0;
      end else if (ctl.enable && less) begin
         count_in = count_ff + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ----- bench/rbcs_rank_checker.sv -----
`timescale 1ns / 1ps
// Rank checker: watches the req_ and rsp_ channels of the rank-by-counting block,
// predicts the rank items of each sequence and compares them in order.
// Depends on rbcs_pkg.
module rbcs_rank_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire rbcs_pkg::rbcs_req_type req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rbcs_pkg::rbcs_rsp_type rsp_data,
   output int                          error_count,
   output int                          outstanding
);
   import rbcs_pkg::*;

   logic signed [VALUE_W-1:0] loaded_values [MAX_ITEMS];
   int                        loaded_count;
   logic                      values_dropped;
   rbcs_rsp_type              pending_ranks [$];
   int                        fail_total = 0;

   task automatic report(input string msg);
      if (fail_total < 10) begin
         $display("%0t ns: %s", $time, msg);
      end
      fail_total++;
   endtask

   always @(posedge clock) begin
      rbcs_rsp_type want;
      int           smaller;
      if (reset) begin
         loaded_count   = 0;
         values_dropped = 1'b0;
         pending_ranks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_ranks.size() == 0) begin
               report($sformatf("unexpected rank item: rank=%0d end=%0b ovf=%0b",
                                rsp_data.rank, rsp_data.end_of_ranks, rsp_data.overflow));
            end else begin
               want = pending_ranks.pop_front();
               if (rsp_data.rank !== want.rank || rsp_data.end_of_ranks !== want.end_of_ranks
                   || rsp_data.overflow !== want.overflow) begin
                  report($sformatf({"rank mismatch: expected rank=%0d end=%0b ovf=%0b, ",
                                    "got rank=%0d end=%0b ovf=%0b"},
                                   want.rank, want.end_of_ranks, want.overflow,
                                   rsp_data.rank, rsp_data.end_of_ranks, rsp_data.overflow));
               end
            end
         end
         if (req_valid && req_ready) begin
            // drop values once the store is full, but remember it
            if (loaded_count < MAX_ITEMS) begin
               loaded_values[loaded_count] = req_data.value;
               loaded_count++;
            end else begin
               values_dropped = 1'b1;
            end
            if (req_data.is_final) begin
               for (int k = 0; k < loaded_count; k++) begin
                  smaller = 0;
                  for (int j = 0; j < loaded_count; j++) begin
                     if (loaded_values[j] < loaded_values[k]) smaller++;
                  end
                  want.rank         = RANK_W'(smaller);
                  want.end_of_ranks = (k == loaded_count - 1);
                  want.overflow     = values_dropped;
                  pending_ranks.push_back(want);
               end
               loaded_count   = 0;
               values_dropped = 1'b0;
            end
         end
      end
      outstanding <= pending_ranks.size();
      error_count <= fail_total;
   end

endmodule

// ----- bench/tb_rank_by_counting_smaller.sv -----
`timescale 1ns / 1ps
// Top of the rank-by-counting bench: clock, reset, value sequences with random
// gaps, a randomly stalling receiver and the verdict.
// Depends on rbcs_pkg, rank_by_counting_smaller and rbcs_rank_checker.
module tb_rank_by_counting_smaller;
   import rbcs_pkg::*;

   typedef enum int {VALUES_WIDE, VALUES_NARROW, VALUES_EDGE} value_mix_type;

   localparam int RANDOM_END = 515;

   logic         clock        = 1'b0;
   logic         reset        = 1'b1;
   logic         req_valid    = 1'b0;
   logic         req_ready;
   rbcs_req_type req_data     = '0;
   logic         rsp_valid;
   logic         rsp_ready    = 1'b0;
   rbcs_rsp_type rsp_data;
   logic         rsp_hold     = 1'b0;
   logic         random_phase = 1'b0;
   int           error_count;
   int           outstanding;
   int           sent         = 0;

   rank_by_counting_smaller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rbcs_rank_checker rank_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [VALUE_W-1:0] draw_value(input value_mix_type mix);
      case (mix)
         VALUES_WIDE:   return $urandom();
         VALUES_NARROW: return int'($urandom_range(0, 15)) - 8;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return '0;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic last,
                             input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: v, is_final: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_sequence(input int len, input value_mix_type mix);
      bit fast;
      fast = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         send_value(draw_value(mix), i == len - 1, fast);
      end
   endtask

   initial begin
      int pick;
      int len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-value sequences at both extremes
      send_value(32'sh8000_0000, 1'b1, 1'b0);
      send_value(32'sh7fff_ffff, 1'b1, 1'b0);
      // extremes and neighbors of zero in one sequence
      send_value(32'sh8000_0000, 1'b0, 1'b0);
      send_value(32'sh7fff_ffff, 1'b0, 1'b0);
      send_value(0, 1'b0, 1'b0);
      send_value(-1, 1'b0, 1'b0);
      send_value(1, 1'b0, 1'b0);
      send_value(32'sh8000_0001, 1'b1, 1'b0);
      // equal values share a rank
      send_value(7, 1'b0, 1'b0);
      send_value(7, 1'b0, 1'b0);
      send_value(7, 1'b1, 1'b0);
      send_value(3, 1'b0, 1'b0);
      send_value(-3, 1'b0, 1'b0);
      send_value(3, 1'b0, 1'b0);
      send_value(-3, 1'b1, 1'b0);

      random_phase <= 1'b1;
      // overrun the store, final item dropped too; then exactly full
      send_sequence(MAX_ITEMS + 2, VALUES_WIDE);
      send_sequence(MAX_ITEMS, VALUES_NARROW);
      while (sent < RANDOM_END) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(1, 8);
         end else if (pick < 92) begin
            len = $urandom_range(9, MAX_ITEMS - 1);
         end else begin
            len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 6);
         end
         send_sequence(len, value_mix_type'($urandom_range(0, 2)));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // catch stray rank items
      repeat (4 * MAX_ITEMS) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // receiver with random gaps and idle-free stretches
   initial begin
      int gap;
      int run_left;
      bit fast;
      run_left = 0;
      fast     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (run_left == 0) begin
            fast     = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(8, 40);
         end
         run_left--;
         gap = fast ? 0 : $urandom_range(0, 9);
         if (gap > 0 || rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // hold off the receiver long enough that the block backs up its input
   initial begin
      @(posedge clock);
      while (!random_phase) @(posedge clock);
      repeat ($urandom_range(0, 200)) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (600) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- rank_by_counting_smaller.f -----
rtl/rbcs_pkg.sv
rtl/rbcs_store.sv
rtl/rbcs_rank_unit.sv
rtl/rank_by_counting_smaller.sv
bench/rbcs_rank_checker.sv
bench/tb_rank_by_counting_smaller.sv
